// ----- rtl/lc3_pkg.sv -----
// Shared types and constants for the LC-3 instruction executor.
// Used by lc3_ctrl, lc3_dp and lc3_instruction_executor_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lc3_pkg;

   localparam logic [15:0] PC_RESET  = 16'h3000;
   localparam logic [15:0] KBSR_ADDR = 16'hFE00;
   localparam logic [15:0] KBDR_ADDR = 16'hFE02;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_EXEC    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   localparam logic [3:0] OPC_BR   = 4'd0;
   localparam logic [3:0] OPC_ADD  = 4'd1;
   localparam logic [3:0] OPC_LD   = 4'd2;
   localparam logic [3:0] OPC_ST   = 4'd3;
   localparam logic [3:0] OPC_JSR  = 4'd4;
   localparam logic [3:0] OPC_AND  = 4'd5;
   localparam logic [3:0] OPC_LDR  = 4'd6;
   localparam logic [3:0] OPC_STR  = 4'd7;
   localparam logic [3:0] OPC_NOT  = 4'd9;
   localparam logic [3:0] OPC_LDI  = 4'd10;
   localparam logic [3:0] OPC_STI  = 4'd11;
   localparam logic [3:0] OPC_JMP  = 4'd12;
   localparam logic [3:0] OPC_LEA  = 4'd14;
   localparam logic [3:0] OPC_TRAP = 4'd15;

   localparam logic [7:0] VEC_GETC  = 8'h20;
   localparam logic [7:0] VEC_OUT   = 8'h21;
   localparam logic [7:0] VEC_PUTS  = 8'h22;
   localparam logic [7:0] VEC_IN    = 8'h23;
   localparam logic [7:0] VEC_PUTSP = 8'h24;
   localparam logic [7:0] VEC_HALT  = 8'h25;

   localparam logic [2:0] FLAG_N = 3'b100;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_P = 3'b001;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [15:0] data;
      logic        key_ready;
      logic [7:0]  key_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_valid;
      logic       halted;
      logic       bad_opcode;
      logic       truncated;
      logic       last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LATCH,
      OP_WRITE_REQ,
      OP_RESTART,
      OP_FETCH,
      OP_IR_LOAD,
      OP_EXEC,
      OP_LOAD_WB,
      OP_READ_IND,
      OP_STORE_IND,
      OP_TRAP,
      OP_STR_READ,
      OP_STR_WORD,
      OP_PUSH_LO,
      OP_PUSH_LO_INC,
      OP_PUSH_HI_INC,
      OP_SPTR_INC,
      OP_SET_TRUNC,
      OP_BUF_READ,
      OP_RSP_CHAR,
      OP_RSP_STATUS
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] trap_vec;
      logic [1:0] action;
      logic       halted;
      logic       clear_done;
      logic       word_zero;
      logic       hi_zero;
      logic       buf_full;
      logic       buf_empty;
      logic       emit_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/lc3_dp.sv -----
// LC-3 datapath: register file, PC, flags, main memory, character buffer, result register.
// Driven by lc3_ctrl through lc3_pkg::dp_cmd_type; depends on lc3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lc3_dp #(
   parameter int MEM_DEPTH = 65536,
   parameter int MAX_CHARS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lc3_pkg::req_type      req_data,
   input  wire lc3_pkg::dp_cmd_type   cmd,
   input  wire logic                  csr_we,
   input  wire logic [15:0]           csr_wdata,
   output lc3_pkg::dp_status_type     status,
   output logic                       rsp_strobe,
   output lc3_pkg::rsp_type           rsp_data
);
   import lc3_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int BW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int NQ = 65535 / MEM_DEPTH;

   function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
      logic [16:0] r;
      r = {1'b0, a};
      for (int k = 1; k <= NQ; k++) begin
         if ({1'b0, a} >= 17'(k * MEM_DEPTH)) begin
            r = {1'b0, a} - 17'(k * MEM_DEPTH);
         end
      end
      return r[AW-1:0];
   endfunction

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      if (v == 16'd0) begin
         return FLAG_Z;
      end else if (v[15]) begin
         return FLAG_N;
      end else begin
         return FLAG_P;
      end
   endfunction

   logic [15:0] mem [MEM_DEPTH];
   logic [7:0]  cbuf [MAX_CHARS];

   req_type     req_ff, req_in;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  flags_ff, flags_in;
   logic        halt_ff, halt_in;
   logic [15:0] start_pc_ff;
   logic [15:0] ir_ff, ir_in;
   logic [15:0] sptr_ff, sptr_in;
   logic [15:0] word_ff, word_in;
   logic        bad_ff, bad_in;
   logic        trunc_ff, trunc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [15:0] rd_addr_ff;
   logic        rd_map_ff, rd_map_in;
   logic [15:0] mem_q_ff;
   logic [7:0]  buf_q_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_strobe_ff, rsp_strobe_in;

   logic        rf_we, r7_we, set_fl;
   logic [2:0]  rf_wa;
   logic [15:0] rf_wd;
   logic        mem_re, mem_we, push, buf_re;
   logic [15:0] mem_raddr, mem_waddr, mem_wdata;
   logic        mem_wclr;
   logic [AW-1:0] mem_widx;
   logic [7:0]  push_c;

   logic [3:0]  opcode;
   logic [2:0]  dr, sr1;
   logic [15:0] ea9, ea6, alu_b, load_val;
   logic        emit_last;

   assign opcode = ir_ff[15:12];
   assign dr     = ir_ff[11:9];
   assign sr1    = ir_ff[8:6];
   assign ea9    = pc_ff + {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign ea6    = regs_ff[sr1] + {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign alu_b  = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];

   always_comb begin
      if (rd_map_ff && rd_addr_ff == KBSR_ADDR) begin
         load_val = {req_ff.key_ready, 15'd0};
      end else if (rd_map_ff && rd_addr_ff == KBDR_ADDR) begin
         load_val = {8'd0, req_ff.key_char};
      end else begin
         load_val = mem_q_ff;
      end
   end

   assign emit_last = (CW'(idx_ff + CW'(1)) == cnt_ff);

   always_comb begin
      req_in        = req_ff;
      pc_in         = pc_ff;
      flags_in      = flags_ff;
      halt_in       = halt_ff;
      ir_in         = ir_ff;
      sptr_in       = sptr_ff;
      word_in       = word_ff;
      bad_in        = bad_ff;
      trunc_in      = trunc_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      clr_ptr_in    = clr_ptr_ff;
      rd_map_in     = rd_map_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rf_we         = 1'b0;
      r7_we         = 1'b0;
      set_fl        = 1'b0;
      rf_wa         = dr;
      rf_wd         = 16'd0;
      mem_re        = 1'b0;
      mem_raddr     = pc_ff;
      mem_we        = 1'b0;
      mem_wclr      = 1'b0;
      mem_waddr     = ea9;
      mem_wdata     = regs_ff[dr];
      push          = 1'b0;
      push_c        = word_ff[7:0];
      buf_re        = 1'b0;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            mem_we     = 1'b1;
            mem_wclr   = 1'b1;
            mem_wdata  = 16'd0;
            clr_ptr_in = clr_ptr_ff + AW'(1);
         end
         OP_LATCH: begin
            req_in   = req_data;
            cnt_in   = '0;
            idx_in   = '0;
            bad_in   = 1'b0;
            trunc_in = 1'b0;
         end
         OP_WRITE_REQ: begin
            mem_we    = 1'b1;
            mem_waddr = req_ff.address;
            mem_wdata = req_ff.data;
         end
         OP_RESTART: begin
            pc_in   = start_pc_ff;
            halt_in = 1'b0;
         end
         OP_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = pc_ff;
            rd_map_in = 1'b1;
         end
         OP_IR_LOAD: begin
            ir_in = load_val;
            pc_in = pc_ff + 16'd1;
         end
         OP_EXEC: begin
            case (opcode)
               OPC_ADD: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wd  = regs_ff[sr1] + alu_b;
               end
               OPC_AND: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wd  = regs_ff[sr1] & alu_b;
               end
               OPC_NOT: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wd  = ~regs_ff[sr1];
               end
               OPC_LEA: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wd  = ea9;
               end
               OPC_BR: begin
                  if ((dr & flags_ff) != 3'd0) begin
                     pc_in = ea9;
                  end
               end
               OPC_JMP: begin
                  pc_in = regs_ff[sr1];
               end
               OPC_JSR: begin
                  r7_we = 1'b1;
                  pc_in = ir_ff[11] ? pc_ff + {{5{ir_ff[10]}}, ir_ff[10:0]} : regs_ff[sr1];
               end
               OPC_LD, OPC_LDI, OPC_STI: begin
                  mem_re    = 1'b1;
                  mem_raddr = ea9;
                  rd_map_in = 1'b1;
               end
               OPC_LDR: begin
                  mem_re    = 1'b1;
                  mem_raddr = ea6;
                  rd_map_in = 1'b1;
               end
               OPC_ST: begin
                  mem_we    = 1'b1;
                  mem_waddr = ea9;
               end
               OPC_STR: begin
                  mem_we    = 1'b1;
                  mem_waddr = ea6;
               end
               OPC_TRAP: begin
                  r7_we = 1'b1;
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
         end
         OP_LOAD_WB: begin
            rf_we  = 1'b1;
            set_fl = 1'b1;
            rf_wd  = load_val;
         end
         OP_READ_IND: begin
            mem_re    = 1'b1;
            mem_raddr = load_val;
            rd_map_in = 1'b1;
         end
         OP_STORE_IND: begin
            mem_we    = 1'b1;
            mem_waddr = load_val;
         end
         OP_TRAP: begin
            case (ir_ff[7:0])
               VEC_GETC: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wa  = 3'd0;
                  rf_wd  = {8'd0, req_ff.key_char};
               end
               VEC_OUT: begin
                  push   = 1'b1;
                  push_c = regs_ff[0][7:0];
               end
               VEC_IN: begin
                  rf_we  = 1'b1;
                  set_fl = 1'b1;
                  rf_wa  = 3'd0;
                  rf_wd  = {8'd0, req_ff.key_char};
                  push   = 1'b1;
                  push_c = req_ff.key_char;
               end
               VEC_PUTS, VEC_PUTSP: begin
                  sptr_in = regs_ff[0];
               end
               VEC_HALT: begin
                  halt_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         OP_STR_READ: begin
            mem_re    = 1'b1;
            mem_raddr = sptr_ff;
            rd_map_in = 1'b0;
         end
         OP_STR_WORD: begin
            word_in = mem_q_ff;
         end
         OP_PUSH_LO: begin
            push = 1'b1;
         end
         OP_PUSH_LO_INC: begin
            push    = 1'b1;
            sptr_in = sptr_ff + 16'd1;
         end
         OP_PUSH_HI_INC: begin
            push    = 1'b1;
            push_c  = word_ff[15:8];
            sptr_in = sptr_ff + 16'd1;
         end
         OP_SPTR_INC: begin
            sptr_in = sptr_ff + 16'd1;
         end
         OP_SET_TRUNC: begin
            trunc_in = 1'b1;
         end
         OP_BUF_READ: begin
            buf_re = 1'b1;
         end
         OP_RSP_CHAR: begin
            rsp_in        = '{out_char: buf_q_ff, out_valid: 1'b1, halted: halt_ff,
                              bad_opcode: bad_ff, truncated: trunc_ff, last: emit_last};
            rsp_strobe_in = 1'b1;
            idx_in        = idx_ff + CW'(1);
         end
         OP_RSP_STATUS: begin
            rsp_in        = '{out_char: 8'd0, out_valid: 1'b0, halted: halt_ff,
                              bad_opcode: bad_ff, truncated: trunc_ff, last: 1'b1};
            rsp_strobe_in = 1'b1;
         end
         default: begin
         end
      endcase

      if (set_fl) begin
         flags_in = flags_of(rf_wd);
      end
      if (push) begin
         cnt_in = cnt_ff + CW'(1);
      end
      mem_widx = mem_wclr ? clr_ptr_ff : mem_index(mem_waddr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 16'd0;
         end
         pc_ff         <= PC_RESET;
         flags_ff      <= FLAG_Z;
         halt_ff       <= 1'b0;
         start_pc_ff   <= PC_RESET;
         bad_ff        <= 1'b0;
         trunc_ff      <= 1'b0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         clr_ptr_ff    <= '0;
         rd_map_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (rf_we) begin
            regs_ff[rf_wa] <= rf_wd;
         end
         if (r7_we) begin
            regs_ff[7] <= pc_ff;
         end
         pc_ff         <= pc_in;
         flags_ff      <= flags_in;
         halt_ff       <= halt_in;
         if (csr_we) begin
            start_pc_ff <= csr_wdata;
         end
         bad_ff        <= bad_in;
         trunc_ff      <= trunc_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         clr_ptr_ff    <= clr_ptr_in;
         rd_map_ff     <= rd_map_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ir_ff   <= ir_in;
      sptr_ff <= sptr_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff   <= mem[mem_index(mem_raddr)];
         rd_addr_ff <= mem_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cbuf[cnt_ff[BW-1:0]] <= push_c;
      end
      if (buf_re) begin
         buf_q_ff <= cbuf[idx_ff[BW-1:0]];
      end
   end

   assign status = '{opcode: opcode, trap_vec: ir_ff[7:0], action: req_ff.action,
                     halted: halt_ff,
                     clear_done: (clr_ptr_ff == AW'(MEM_DEPTH - 1)),
                     word_zero: (word_ff == 16'd0),
                     hi_zero: (word_ff[15:8] == 8'd0),
                     buf_full: (cnt_ff == CW'(MAX_CHARS)),
                     buf_empty: (cnt_ff == '0),
                     emit_last: emit_last};

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_CHARS))
      else $error("char count beyond limit");
   a_trunc_full: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> cnt_ff == CW'(MAX_CHARS))
      else $error("truncation with buffer not full");
   a_char_buffered: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.out_valid |-> cnt_ff != '0)
      else $error("char result with empty buffer");
`endif

endmodule

`default_nettype wire

// ----- rtl/lc3_ctrl.sv -----
// LC-3 controller: sequences memory clear, item dispatch, instruction steps and result output.
// Commands lc3_dp through lc3_pkg::dp_cmd_type; depends on lc3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lc3_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire lc3_pkg::dp_status_type status,
   output logic                        busy,
   output lc3_pkg::dp_cmd_type         cmd
);
   import lc3_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_FETCH,
      ST_IR,
      ST_EXEC,
      ST_LOAD_WB,
      ST_IND,
      ST_STI,
      ST_TRAP,
      ST_STR_RD,
      ST_STR_WORD,
      ST_STR_LO,
      ST_STR_HI,
      ST_RESP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESP;
            priority if (status.action == ACT_WRITE) begin
               cmd.op = OP_WRITE_REQ;
            end else if (status.action == ACT_RESTART) begin
               cmd.op = OP_RESTART;
            end else if (status.action == ACT_EXEC && !status.halted) begin
               state_in = ST_FETCH;
            end else begin
               cmd.op = OP_NONE;
            end
         end
         ST_FETCH: begin
            cmd.op   = OP_FETCH;
            state_in = ST_IR;
         end
         ST_IR: begin
            cmd.op   = OP_IR_LOAD;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.op = OP_EXEC;
            priority if (status.opcode == OPC_LD || status.opcode == OPC_LDR) begin
               state_in = ST_LOAD_WB;
            end else if (status.opcode == OPC_LDI) begin
               state_in = ST_IND;
            end else if (status.opcode == OPC_STI) begin
               state_in = ST_STI;
            end else if (status.opcode == OPC_TRAP) begin
               state_in = ST_TRAP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LOAD_WB: begin
            cmd.op   = OP_LOAD_WB;
            state_in = ST_RESP;
         end
         ST_IND: begin
            cmd.op   = OP_READ_IND;
            state_in = ST_LOAD_WB;
         end
         ST_STI: begin
            cmd.op   = OP_STORE_IND;
            state_in = ST_RESP;
         end
         ST_TRAP: begin
            cmd.op = OP_TRAP;
            if (status.trap_vec == VEC_PUTS || status.trap_vec == VEC_PUTSP) begin
               state_in = ST_STR_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_STR_RD: begin
            cmd.op   = OP_STR_READ;
            state_in = ST_STR_WORD;
         end
         ST_STR_WORD: begin
            cmd.op   = OP_STR_WORD;
            state_in = ST_STR_LO;
         end
         ST_STR_LO: begin
            priority if (status.word_zero) begin
               state_in = ST_RESP;
            end else if (status.buf_full) begin
               cmd.op   = OP_SET_TRUNC;
               state_in = ST_RESP;
            end else if (status.trap_vec == VEC_PUTS) begin
               cmd.op   = OP_PUSH_LO_INC;
               state_in = ST_STR_RD;
            end else begin
               cmd.op   = OP_PUSH_LO;
               state_in = ST_STR_HI;
            end
         end
         ST_STR_HI: begin
            priority if (status.hi_zero) begin
               cmd.op   = OP_SPTR_INC;
               state_in = ST_STR_RD;
            end else if (status.buf_full) begin
               cmd.op   = OP_SET_TRUNC;
               state_in = ST_RESP;
            end else begin
               cmd.op   = OP_PUSH_HI_INC;
               state_in = ST_STR_RD;
            end
         end
         ST_RESP: begin
            if (status.buf_empty) begin
               cmd.op   = OP_RSP_STATUS;
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_BUF_READ;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.op   = OP_RSP_CHAR;
            state_in = status.emit_last ? ST_IDLE : ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef ASSERT_OFF
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RSP_STATUS |=> !busy)
      else $error("status result did not end the item");
   a_emit_read: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RSP_CHAR |-> $past(cmd.op) == OP_BUF_READ)
      else $error("char result without buffer read");
`endif

endmodule

`default_nettype wire

// ----- rtl/lc3_instruction_executor_unit.sv -----
// Top level of the LC-3 instruction executor: lc3_ctrl sequencer plus lc3_dp datapath.
// Depends on lc3_pkg, lc3_ctrl and lc3_dp.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block sweeps main memory to zero, one word per cycle, with busy high;
// csr writes are taken throughout. An item is accepted when start is high and busy is
// low. A memory write, restart or halted step puts out its single status result; an
// instruction first fetches, then makes up to two dependent memory reads. A trap passes
// through one more state, each character is read out of the buffer before it is put
// out where a status result is put out directly, and PUTS/PUTSP read, latch and push
// each string word in turn. Results appear on rsp_data for one cycle with rsp_strobe
// high and cannot be stalled.
module lc3_instruction_executor_unit #(
   parameter int MEM_DEPTH = 65536,
   parameter int MAX_CHARS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lc3_pkg::req_type  req_data,
   output logic                   rsp_strobe,
   output lc3_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_wdata
);
   import lc3_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lc3_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   lc3_dp #(
      .MEM_DEPTH (MEM_DEPTH),
      .MAX_CHARS (MAX_CHARS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for lc3_instruction_executor_unit: directed and random LC-3 programs.
// Predicts each result item with an internal LC-3 model; depends on lc3_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import lc3_pkg::*;

   localparam int MEM_DEPTH = 65536;
   localparam int MAX_CHARS = 64;
   localparam int WATCHDOG  = 200000;

   logic clock, reset, start, busy, rsp_strobe, csr_we;
   logic [15:0] csr_wdata;
   req_type req_data;
   rsp_type rsp_data;

   lc3_instruction_executor_unit #(.MEM_DEPTH(MEM_DEPTH), .MAX_CHARS(MAX_CHARS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // model state
   logic [15:0] m_reg [8];
   logic [15:0] m_pc, m_start_pc;
   logic [2:0]  m_cc;
   logic        m_halt;
   logic [15:0] m_mem [MEM_DEPTH];
   logic        k_ready;
   logic [15:0] k_char;
   logic [7:0]  out_buf [$];
   logic        out_trunc;

   rsp_type pending_rsp [$];
   int      errors;
   int      idle_pct;
   int      stall_cnt;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
      logic [15:0] r;
      r = v & ((16'd1 << bits) - 16'd1);
      if (r[bits-1]) r = r | ~((16'd1 << bits) - 16'd1);
      return r;
   endfunction

   function automatic logic [15:0] mread(input logic [15:0] a);
      if (a == KBSR_ADDR) return k_ready ? 16'h8000 : 16'h0000;
      if (a == KBDR_ADDR) return k_char;
      return m_mem[a % MEM_DEPTH];
   endfunction

   function automatic void flags(input logic [15:0] v);
      m_cc = (v == 16'd0) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
   endfunction

   function automatic bit put_char(input logic [7:0] c);
      if (out_buf.size() >= MAX_CHARS) begin
         out_trunc = 1'b1;
         return 0;
      end
      out_buf.push_back(c);
      return 1;
   endfunction

   function automatic void run_trap(input logic [7:0] vec);
      logic [15:0] a, w;
      a = m_reg[0];
      case (vec)
         VEC_GETC: begin m_reg[0] = k_char; flags(m_reg[0]); end
         VEC_OUT:  void'(put_char(m_reg[0][7:0]));
         VEC_PUTS:
            forever begin
               w = m_mem[a % MEM_DEPTH];
               if (w == 16'd0 || !put_char(w[7:0])) break;
               a = a + 16'd1;
            end
         VEC_IN: begin
            m_reg[0] = k_char; void'(put_char(k_char[7:0])); flags(m_reg[0]);
         end
         VEC_PUTSP:
            forever begin
               w = m_mem[a % MEM_DEPTH];
               if (w == 16'd0 || !put_char(w[7:0])) break;
               if (w[15:8] != 8'd0 && !put_char(w[15:8])) break;
               a = a + 16'd1;
            end
         VEC_HALT: m_halt = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic bit run_instr();
      logic [15:0] ins, pc, b, v, t;
      logic [2:0] dr, sr1;
      bit bad;
      bad = 0;
      ins = mread(m_pc);
      pc = m_pc + 16'd1;
      dr = ins[11:9];
      sr1 = ins[8:6];
      m_pc = pc;
      case (ins[15:12])
         OPC_ADD, OPC_AND: begin
            b = ins[5] ? sx(ins, 5) : m_reg[ins[2:0]];
            v = (ins[15:12] == OPC_ADD) ? m_reg[sr1] + b : m_reg[sr1] & b;
            m_reg[dr] = v; flags(v);
         end
         OPC_NOT: begin v = ~m_reg[sr1]; m_reg[dr] = v; flags(v); end
         OPC_BR: if ((dr & m_cc) != 3'd0) m_pc = pc + sx(ins, 9);
         OPC_JMP: m_pc = m_reg[sr1];
         OPC_JSR: begin
            t = pc;
            m_pc = ins[11] ? pc + sx(ins, 11) : m_reg[sr1];
            m_reg[7] = t;
         end
         OPC_LD: begin v = mread(pc + sx(ins, 9)); m_reg[dr] = v; flags(v); end
         OPC_LDI: begin v = mread(mread(pc + sx(ins, 9))); m_reg[dr] = v; flags(v); end
         OPC_LDR: begin v = mread(m_reg[sr1] + sx(ins, 6)); m_reg[dr] = v; flags(v); end
         OPC_LEA: begin v = pc + sx(ins, 9); m_reg[dr] = v; flags(v); end
         OPC_ST: m_mem[(pc + sx(ins, 9)) % MEM_DEPTH] = m_reg[dr];
         OPC_STI: m_mem[mread(pc + sx(ins, 9)) % MEM_DEPTH] = m_reg[dr];
         OPC_STR: m_mem[(m_reg[sr1] + sx(ins, 6)) % MEM_DEPTH] = m_reg[dr];
         OPC_TRAP: begin m_reg[7] = pc; run_trap(ins[7:0]); end
         default: bad = 1;
      endcase
      return bad;
   endfunction

   function automatic void predict_step(input req_type it);
      bit bad;
      int n;
      rsp_type r;
      bad = 0;
      k_ready = it.key_ready;
      k_char = {8'h00, it.key_char};
      out_buf.delete();
      out_trunc = 1'b0;
      case (it.action)
         ACT_WRITE: m_mem[it.address % MEM_DEPTH] = it.data;
         ACT_EXEC: if (!m_halt) bad = run_instr();
         ACT_RESTART: begin m_pc = m_start_pc; m_halt = 1'b0; end
         default: ;
      endcase
      n = (out_buf.size() > 0) ? out_buf.size() : 1;
      for (int k = 0; k < n; k++) begin
         r.out_char = (out_buf.size() > 0) ? out_buf[k] : 8'h00;
         r.out_valid = out_buf.size() > 0;
         r.halted = m_halt;
         r.bad_opcode = bad;
         r.truncated = out_trunc;
         r.last = (k == n - 1);
         pending_rsp.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected result %h", rsp_data));
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.out_char !== e.out_char)
               report($sformatf("out_char %h exp %h", rsp_data.out_char, e.out_char));
            if (rsp_data.out_valid !== e.out_valid)
               report($sformatf("out_valid %b exp %b", rsp_data.out_valid, e.out_valid));
            if (rsp_data.halted !== e.halted)
               report($sformatf("halted %b exp %b", rsp_data.halted, e.halted));
            if (rsp_data.bad_opcode !== e.bad_opcode)
               report($sformatf("bad_opcode %b exp %b", rsp_data.bad_opcode, e.bad_opcode));
            if (rsp_data.truncated !== e.truncated)
               report($sformatf("truncated %b exp %b", rsp_data.truncated, e.truncated));
            if (rsp_data.last !== e.last)
               report($sformatf("last %b exp %b", rsp_data.last, e.last));
         end
      end
   end

   // watchdog: cycles with no accepted item and no result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                            input logic [15:0] dat, input logic kr, input logic [7:0] kc);
      req_type it;
      it.action = act; it.address = addr; it.data = dat;
      it.key_ready = kr; it.key_char = kc;
      @(posedge clock);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_step(it);
      start <= 0;
   endtask

   task automatic poke(input logic [15:0] addr, input logic [15:0] dat);
      send_item(ACT_WRITE, addr, dat, 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   task automatic step(input logic kr = 0, input logic [7:0] kc = 8'h41);
      send_item(ACT_EXEC, 16'($urandom), 16'($urandom), kr, kc);
   endtask

   task automatic restart();
      send_item(ACT_RESTART, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                8'($urandom_range(255)));
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_start_pc(input logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      m_start_pc = v;
   endtask

   task automatic test_directed();
      set_start_pc(16'h3000);
      restart();
      poke(16'h3000, 16'h1021);                       // ADD R0,R0,#1
      poke(16'h3001, 16'h5020);                       // AND R0,R0,#0
      poke(16'h3002, 16'h903F);                       // NOT R0,R0
      poke(16'h3003, 16'h0E01);                       // BRnzp +1
      poke(16'h3005, 16'h23FC);                       // LD R1
      poke(16'h3006, 16'hF020);                       // GETC
      poke(16'h3007, 16'hF023);                       // IN
      poke(16'h3008, 16'hF021);                       // OUT
      poke(16'h3009, 16'h8000);                       // RTI
      poke(16'h300A, 16'hD000);                       // reserved
      poke(16'h300B, 16'hF0FF);                       // unknown vector
      poke(16'h300C, 16'hF025);                       // HALT
      for (int i = 0; i < 12; i++) step(1'($urandom_range(1)), 8'($urandom_range(255)));
      step();                                         // halted: ignored
      restart();
   endtask

   task automatic test_keyboard();
      set_start_pc(16'h4000);
      restart();
      poke(16'h4000, 16'h2000 | 16'h0002 | (16'd2 << 9)); // LD R2, 0x4003
      poke(16'h4001, 16'hA000 | 16'h0002 | (16'd3 << 9)); // LDI R3, [0x4004]
      poke(16'h4003, KBSR_ADDR);
      poke(16'h4002, 16'h0FFF);
      poke(16'h4004, KBDR_ADDR);
      poke(16'h4005, 16'hFFFF);
      step(1, 8'hFF);
      step(0, 8'h80);
      drain();
      // string traps: short and truncated
      set_start_pc(16'h5000);
      restart();
      poke(16'h5000, 16'hE1FF);                       // LEA R0, 0x5000
      for (int i = 0; i < 3; i++) poke(16'(16'h6000 + i), 16'(16'h0041 + i));
      poke(16'h5001, 16'h2001);                       // LD R0, 0x5003
      poke(16'h5002, 16'hF022);
      poke(16'h5003, 16'h6000);
      step(); step(); step();
      for (int i = 0; i < 70; i++) poke(16'(16'h7000 + i), 16'(16'h4100 + i + 1));
      poke(16'h7046, 16'h0000);
      poke(16'h5004, 16'h2001);                       // LD R0, 0x5006
      poke(16'h5005, 16'hF024);
      poke(16'h5006, 16'h7000);
      poke(16'h5007, 16'hF022);                       // PUTS 70 chars
      step(); step(); step();
      poke(16'hFFFF, 16'h0158);                       // PUTSP wrap data, not executed by the steps below
      poke(16'h0000, 16'h005A);
      poke(16'h0001, 16'h0000);
      poke(16'h5008, 16'h2001);
      poke(16'h5009, 16'hF024);
      poke(16'h500A, 16'hFFFF);
      step(); step();
      drain();
   endtask

   function automatic logic [15:0] rand_instr();
      logic [15:0] ins;
      ins = 16'($urandom);
      case ($urandom_range(15))
         0, 1: ins[15:12] = OPC_ADD;
         2: ins[15:12] = OPC_AND;
         3: ins[15:12] = OPC_NOT;
         4: ins[15:12] = OPC_BR;
         5: begin ins[15:12] = OPC_TRAP; ins[7:0] = VEC_GETC + 8'($urandom_range(5)); end
         6: ins[15:12] = OPC_LDR;
         7: ins[15:12] = OPC_STR;
         8: ins[15:12] = OPC_LEA;
         9: ins[15:12] = OPC_LD;
         10: ins[15:12] = OPC_ST;
         default: ;
      endcase
      if (ins[15:12] == OPC_TRAP && ins[7:0] == VEC_HALT && $urandom_range(3) != 0)
         ins[7:0] = VEC_OUT;
      return ins;
   endfunction

   task automatic test_random(input int n_items);
      logic [15:0] base;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         base = $urandom_range(1) ? 16'h3000 : 16'($urandom);
         base[2:0] = 3'd0;
         set_start_pc(base);
         restart();
         for (int i = 0; i < 8; i++) begin
            poke(16'(base + i), rand_instr());
            poke(16'(base + 16'h0040 + i), {1'b0, 7'($urandom), 8'($urandom)});
         end
         sent += 17;
         for (int i = 0; i < 10; i++) begin
            if ($urandom_range(9) == 0) poke(16'($urandom), 16'($urandom));
            else if ($urandom_range(19) == 0)
               send_item(ACT_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                         8'($urandom));
            else step(1'($urandom_range(1)), 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      errors = 0;
      idle_pct = 15;
      start = 0;
      reset = 1;
      csr_we = 0;
      csr_wdata = 16'h0000;
      req_data = '0;
      m_start_pc = PC_RESET;
      m_pc = PC_RESET;
      m_cc = FLAG_Z;
      m_halt = 1'b0;
      for (int i = 0; i < 8; i++) m_reg[i] = '0;
      for (int i = 0; i < MEM_DEPTH; i++) m_mem[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      test_keyboard();
      set_start_pc(16'hFFFF);
      set_start_pc(16'h0000);
      test_random(80);
      idle_pct = 68;
      test_random(80);
      idle_pct = 0;
      test_random(80);
      drain();
      if (errors == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule
